>>> rtl/core/assert_macros.svh
// Assertion macros used by the checker file of this core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge and skip it while reset is held.
`define CHK_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check a property on every rising edge, reset cycles included.
`define CHK_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/gf2arb_pkg.sv
// Shared types, codes and widths of the GF(2) affine rank basis core.
package gf2arb_pkg;

    // Default vector width of the basis.
    localparam int VECTOR_WIDTH_DEF = 32;

    // Fixed field widths.
    localparam int MODE_W    = 2;
    localparam int VALUE_W   = 32;
    localparam int ROW_IDX_W = 5;
    localparam int RANK_W    = 6;
    localparam int COUNT_W   = 33;
    localparam int DATA_W    = 32;

    // Packed stream widths; the tdata widths are rounded up to whole bytes.
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 72;
    localparam int S_TUSER_W = MODE_W;
    localparam int M_TUSER_W = 2;

    // Command queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    // Mode codes on the input tuser.
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

    typedef enum logic [1:0] {
        OP_INSERT,
        OP_READ,
        OP_CLEAR,
        OP_NOP
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_READ,
        ST_DONE
    } state_t;

    // Decoded command, minus the vector payload.
    typedef struct packed {
        op_t                  op;
        logic [ROW_IDX_W-1:0] row_index;
    } cmd_ctl_t;

    // One result item.
    typedef struct packed {
        logic               independent;
        logic               took_offset;
        logic [RANK_W-1:0]  rank;
        logic [COUNT_W-1:0] item_count;
        logic [DATA_W-1:0]  row_data;
    } res_t;

endpackage

>>> rtl/core/gf2arb_front.sv
// Front end: accepts input items, decodes the mode and queues commands.
module gf2arb_front #(
    parameter int VECTOR_WIDTH = gf2arb_pkg::VECTOR_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [gf2arb_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic [gf2arb_pkg::S_TUSER_W-1:0]    s_tuser,
    output logic                                cmd_valid,
    input  logic                                cmd_ready,
    output gf2arb_pkg::cmd_ctl_t                cmd_ctl,
    output logic [VECTOR_WIDTH-1:0]             cmd_value
);
    import gf2arb_pkg::*;

    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    cmd_ctl_t                q_ctl_reg [QUEUE_DEPTH];
    logic [VECTOR_WIDTH-1:0] q_val_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0]       fill_reg, fill_next;
    cmd_ctl_t                dec_ctl;
    logic                    push;
    logic                    pop;

    // Decode the mode; unused codes become a no-op
    always_comb begin
        dec_ctl.row_index = s_tdata[VALUE_W +: ROW_IDX_W];
        unique case (s_tuser)
            MODE_INSERT: dec_ctl.op = OP_INSERT;
            MODE_READ:   dec_ctl.op = OP_READ;
            MODE_CLEAR:  dec_ctl.op = OP_CLEAR;
            default:     dec_ctl.op = OP_NOP;
        endcase
    end

    assign s_tready  = (fill_reg != FILL_W'(QUEUE_DEPTH));
    assign cmd_valid = (fill_reg != '0);
    assign push      = s_tvalid && s_tready;
    assign pop       = cmd_valid && cmd_ready;
    assign cmd_ctl   = q_ctl_reg[rd_ptr_reg];
    assign cmd_value = q_val_reg[rd_ptr_reg];

    // Advance pointers and fill level
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Store the queued payload
    always_ff @(posedge aclk) begin
        if (push) begin
            q_ctl_reg[wr_ptr_reg] <= dec_ctl;
            q_val_reg[wr_ptr_reg] <= VECTOR_WIDTH'(s_tdata[VALUE_W-1:0]);
        end
    end

endmodule

>>> rtl/core/gf2arb_back.sv
// Back end: basis memory, row-by-row reduction, reads, clears and result register.
module gf2arb_back #(
    parameter int VECTOR_WIDTH = gf2arb_pkg::VECTOR_WIDTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cmd_valid,
    output logic                        cmd_ready,
    input  gf2arb_pkg::cmd_ctl_t        cmd_ctl,
    input  logic [VECTOR_WIDTH-1:0]     cmd_value,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output gf2arb_pkg::res_t            m_res
);
    import gf2arb_pkg::*;

    localparam int AW = $clog2(VECTOR_WIDTH);
    localparam logic [AW-1:0] TOP_ROW = AW'(VECTOR_WIDTH - 1);

    // Basis memory, one row per leading bit
    logic [VECTOR_WIDTH-1:0] mem [VECTOR_WIDTH];
    logic [VECTOR_WIDTH-1:0] rd_data_reg;
    logic [AW-1:0]           rd_addr;
    logic                    mem_we;

    state_t                  state_reg, state_next;
    logic [AW-1:0]           bit_reg, bit_next;
    logic [VECTOR_WIDTH-1:0] r_reg, r_next;
    logic [VECTOR_WIDTH-1:0] r_x;
    logic [AW-1:0]           addr_reg, addr_next;
    logic                    row_ok_reg, row_ok_next;
    logic                    indep_reg, indep_next;
    logic                    took_reg, took_next;
    logic [DATA_W-1:0]       data_reg, data_next;
    logic [VECTOR_WIDTH-1:0] offset_reg, offset_next;
    logic                    offset_valid_reg, offset_valid_next;
    logic [RANK_W-1:0]       rank_reg, rank_next;
    logic [COUNT_W-1:0]      count_reg, count_next;
    logic [VECTOR_WIDTH-1:0] valid_reg, valid_next;
    logic                    out_valid_reg, out_valid_next;
    res_t                    out_reg, out_next;
    logic [AW+ROW_IDX_W-1:0] idx_ext;
    logic                    cmd_row_ok;

    assign m_tvalid = out_valid_reg;
    assign m_res    = out_reg;

    // Map the requested row onto the memory address range
    assign idx_ext    = {{AW{1'b0}}, cmd_ctl.row_index};
    assign cmd_row_ok = ({{(32 - ROW_IDX_W){1'b0}}, cmd_ctl.row_index} < 32'(VECTOR_WIDTH));

    // Remainder after folding in the current row
    assign r_x = r_reg[bit_reg] ? (r_reg ^ rd_data_reg) : r_reg;

    // Sequence one command at a time
    always_comb begin
        state_next        = state_reg;
        bit_next          = bit_reg;
        r_next            = r_reg;
        addr_next         = addr_reg;
        row_ok_next       = row_ok_reg;
        indep_next        = indep_reg;
        took_next         = took_reg;
        data_next         = data_reg;
        offset_next       = offset_reg;
        offset_valid_next = offset_valid_reg;
        rank_next         = rank_reg;
        count_next        = count_reg;
        valid_next        = valid_reg;
        out_next          = out_reg;
        out_valid_next    = out_valid_reg;
        cmd_ready         = 1'b0;
        rd_addr           = bit_reg;
        mem_we            = 1'b0;

        // Drop the result once it is taken
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    cmd_ready  = 1'b1;
                    indep_next = 1'b0;
                    took_next  = 1'b0;
                    data_next  = '0;
                    unique case (cmd_ctl.op)
                        OP_INSERT: begin
                            if (count_reg != {COUNT_W{1'b1}}) begin
                                count_next = count_reg + 1'b1;
                            end
                            if (!offset_valid_reg) begin
                                offset_next       = cmd_value;
                                offset_valid_next = 1'b1;
                                took_next         = 1'b1;
                                state_next        = ST_DONE;
                            end else begin
                                r_next     = cmd_value ^ offset_reg;
                                bit_next   = TOP_ROW;
                                rd_addr    = TOP_ROW;
                                state_next = ST_RUN;
                            end
                        end
                        OP_READ: begin
                            addr_next   = idx_ext[AW-1:0];
                            row_ok_next = cmd_row_ok;
                            rd_addr     = idx_ext[AW-1:0];
                            state_next  = ST_READ;
                        end
                        OP_CLEAR: begin
                            valid_next        = '0;
                            rank_next         = '0;
                            count_next        = '0;
                            offset_next       = '0;
                            offset_valid_next = 1'b0;
                            state_next        = ST_DONE;
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_READ: begin
                if (row_ok_reg && valid_reg[addr_reg]) begin
                    data_next = DATA_W'(rd_data_reg);
                end
                state_next = ST_DONE;
            end
            ST_RUN: begin
                if (r_reg[bit_reg] && !valid_reg[bit_reg]) begin
                    // Empty row at the leading bit: store the remainder there
                    mem_we              = 1'b1;
                    valid_next[bit_reg] = 1'b1;
                    if (rank_reg != {RANK_W{1'b1}}) begin
                        rank_next = rank_reg + 1'b1;
                    end
                    indep_next = 1'b1;
                    data_next  = DATA_W'(r_reg);
                    state_next = ST_DONE;
                end else begin
                    r_next = r_x;
                    if (bit_reg == '0) begin
                        data_next  = DATA_W'(r_x);
                        state_next = ST_DONE;
                    end else begin
                        bit_next = bit_reg - 1'b1;
                        rd_addr  = bit_reg - 1'b1;
                    end
                end
            end
            ST_DONE: begin
                // Hold until the result register is free
                if (!out_valid_reg || m_tready) begin
                    out_valid_next      = 1'b1;
                    out_next.independent = indep_reg;
                    out_next.took_offset = took_reg;
                    out_next.rank        = rank_reg;
                    out_next.item_count  = count_reg;
                    out_next.row_data    = data_reg;
                    state_next           = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            offset_valid_reg <= 1'b0;
            rank_reg         <= '0;
            count_reg        <= '0;
            valid_reg        <= '0;
            out_valid_reg    <= 1'b0;
        end else begin
            state_reg        <= state_next;
            offset_valid_reg <= offset_valid_next;
            rank_reg         <= rank_next;
            count_reg        <= count_next;
            valid_reg        <= valid_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Working payload registers
    always_ff @(posedge aclk) begin
        bit_reg    <= bit_next;
        r_reg      <= r_next;
        addr_reg   <= addr_next;
        row_ok_reg <= row_ok_next;
        indep_reg  <= indep_next;
        took_reg   <= took_next;
        data_reg   <= data_next;
        offset_reg <= offset_next;
        out_reg    <= out_next;
    end

    // Write and read the basis memory
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[bit_reg] <= r_reg;
        end
        rd_data_reg <= mem[rd_addr];
    end

endmodule

>>> rtl/core/gf2_affine_rank_basis_core.sv
// Top level of the GF(2) affine rank basis core.
// Insert: the first insert after a clear or reset stores the vector as the offset;
//   later inserts reduce it against the rows read from the row memory, top row first.
// Reads, clears and unused modes, like inserts, are handled one item at a time.
// A two-item command queue keeps input accepted while the back end works, as long as it has room.
// Reset (aresetn low, synchronous) empties the queue and clears rank, count,
//   the offset valid flag and all row valid bits at once.
module gf2_affine_rank_basis_core #(
    parameter int VECTOR_WIDTH = gf2arb_pkg::VECTOR_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // value [31:0], row_index [36:32], zero [39:37]
    input  logic [gf2arb_pkg::S_TDATA_W-1:0]    s_tdata,
    // mode [1:0]
    input  logic [gf2arb_pkg::S_TUSER_W-1:0]    s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // rank [5:0], item_count [38:6], row_data [70:39], zero [71]
    output logic [gf2arb_pkg::M_TDATA_W-1:0]    m_tdata,
    // independent [0], took_offset [1]
    output logic [gf2arb_pkg::M_TUSER_W-1:0]    m_tuser
);
    import gf2arb_pkg::*;

    logic                    cmd_valid;
    logic                    cmd_ready;
    cmd_ctl_t                cmd_ctl;
    logic [VECTOR_WIDTH-1:0] cmd_value;
    res_t                    res;

    gf2arb_front #(
        .VECTOR_WIDTH(VECTOR_WIDTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_ctl   (cmd_ctl),
        .cmd_value (cmd_value)
    );

    gf2arb_back #(
        .VECTOR_WIDTH(VECTOR_WIDTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_ctl   (cmd_ctl),
        .cmd_value (cmd_value),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_res     (res)
    );

    // Pack the result item
    assign m_tdata = {1'b0, res.row_data, res.item_count, res.rank};
    assign m_tuser = {res.took_offset, res.independent};

endmodule

>>> rtl/core/gf2arb_checker.sv
// Port-level checks of the GF(2) affine rank basis core, bound to the top level.
`include "assert_macros.svh"

module gf2arb_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic [gf2arb_pkg::S_TDATA_W-1:0]    s_tdata,
    input logic [gf2arb_pkg::S_TUSER_W-1:0]    s_tuser,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [gf2arb_pkg::M_TDATA_W-1:0]    m_tdata,
    input logic [gf2arb_pkg::M_TUSER_W-1:0]    m_tuser
);
    // After reset the queue is empty and no result is pending
    `CHK_ASSERT_RST(a_reset_idle, aclk, !aresetn |=> (s_tready && !m_tvalid), "not idle after reset")

    // A stalled result holds
    `CHK_ASSERT(a_out_hold, aclk, aresetn, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)), "result changed while stalled")

    // An offset insert never extends the basis, gives a zero remainder and is counted
    `CHK_ASSERT(a_offset_res, aclk, aresetn, (m_tvalid && m_tuser[1]) |-> (!m_tuser[0] && (m_tdata[70:39] == 32'd0) && (m_tdata[38:6] != 33'd0)), "bad offset result")

    // A basis extension leaves a nonzero rank
    `CHK_ASSERT(a_indep_rank, aclk, aresetn, (m_tvalid && m_tuser[0]) |-> (m_tdata[5:0] != 6'd0), "independent insert with zero rank")

endmodule

bind gf2_affine_rank_basis_core gf2arb_checker u_gf2arb_checker (.*);
